// ----- sv/sab_pkg.sv -----
// Shared types, register indexes and pixel helper functions for the sprite blender.
package sab_pkg;

	// Load enables for the three pipeline stages.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

	localparam int REG_IDX_W = 2;
	localparam int CFG_DATA_W = 11;

	localparam logic [REG_IDX_W-1:0] REG_SPRITE_LEFT   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SPRITE_TOP    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SPRITE_WIDTH  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_SPRITE_HEIGHT = 2'd3;

	localparam int ADDR_W = 17;
	localparam int COLOR_W = 16;

	typedef logic [7:0] exp5_tab_t [32];
	typedef logic [7:0] exp6_tab_t [64];

	function automatic exp5_tab_t build_exp5();
		exp5_tab_t t;
		for (int i = 0; i < 32; i++) begin
			t[i] = 8'((i * 255) / 31);
		end
		return t;
	endfunction

	function automatic exp6_tab_t build_exp6();
		exp6_tab_t t;
		for (int i = 0; i < 64; i++) begin
			t[i] = 8'((i * 255) / 63);
		end
		return t;
	endfunction

	// Channel expansion from 5 and 6 bits to 8 bits, rounded down.
	localparam exp5_tab_t EXP5 = build_exp5();
	localparam exp6_tab_t EXP6 = build_exp6();

	function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

	// Exact floor(x / 255) for x up to 255 * 255.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
		return t[15:8];
	endfunction

endpackage

// ----- sv/sab_geom.sv -----
// Clipping against sprite and screen bounds, and framebuffer address computation.
module sab_geom import sab_pkg::*; #(
	parameter int SCREEN_WIDTH = 320,
	parameter int SCREEN_HEIGHT = 240,
	parameter int MAX_SPRITE_SIDE = 256
) (
	input  logic               clk,
	input  stage_en_t          en,
	input  logic signed [10:0] sprite_left,
	input  logic signed [10:0] sprite_top,
	input  logic [8:0]         sprite_width,
	input  logic [8:0]         sprite_height,
	input  logic [7:0]         sprite_col,
	input  logic [7:0]         sprite_line,
	input  logic [7:0]         alpha,
	output logic               we_s2,
	output logic [ADDR_W-1:0]  addr_s2
);

	localparam logic [11:0] SW_L = 12'(SCREEN_WIDTH);
	localparam logic [11:0] SH_L = 12'(SCREEN_HEIGHT);
	localparam logic [10:0] MAX_L = 11'(MAX_SPRITE_SIDE);

	logic [11:0] sx;
	logic [11:0] sy;
	logic [10:0] w_eff;
	logic [10:0] h_eff;
	logic        in_sprite;
	logic        on_screen;
	logic        we_d;
	logic        we_s1;
	logic [10:0] sx_s1;
	logic [10:0] sy_s1;
	logic [23:0] lin;

	// Twelve bits hold any sum of an 11-bit signed origin and an 8-bit offset.
	assign sx = {sprite_left[10], sprite_left} + {4'd0, sprite_col};
	assign sy = {sprite_top[10], sprite_top} + {4'd0, sprite_line};

	assign w_eff = ({2'd0, sprite_width} > MAX_L) ? MAX_L : {2'd0, sprite_width};
	assign h_eff = ({2'd0, sprite_height} > MAX_L) ? MAX_L : {2'd0, sprite_height};

	assign in_sprite = ({3'd0, sprite_col} < w_eff) && ({3'd0, sprite_line} < h_eff);
	assign on_screen = !sx[11] && ({1'b0, sx[10:0]} < SW_L)
		&& !sy[11] && ({1'b0, sy[10:0]} < SH_L);
	assign we_d = in_sprite && on_screen && (alpha != 8'd0);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			we_s1 <= we_d;
			sx_s1 <= sx[10:0];
			sy_s1 <= sy[10:0];
		end
	end

	assign lin = 24'(sy_s1) * 24'(SCREEN_WIDTH) + 24'(sx_s1);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			we_s2 <= we_s1;
			addr_s2 <= we_s1 ? lin[ADDR_W-1:0] : '0;
		end
	end

endmodule

// ----- sv/sab_blend.sv -----
// Alpha blend datapath: channel expansion, weighted sums and division by 255.
module sab_blend import sab_pkg::*; (
	input  logic               clk,
	input  stage_en_t          en,
	input  logic [31:0]        src_pixel,
	input  logic [15:0]        dst_pixel,
	input  logic               we_s2,
	output logic [COLOR_W-1:0] color
);

	logic [7:0]  a_s1;
	logic [7:0]  na_s1;
	logic [7:0]  sr_s1, sg_s1, sb_s1;
	logic [7:0]  dr_s1, dg_s1, db_s1;
	logic        opq_s1;
	logic [15:0] mr_s2, mg_s2, mb_s2;
	logic [15:0] src565_s2;
	logic        opq_s2;
	logic [15:0] mixed;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			a_s1 <= src_pixel[31:24];
			na_s1 <= ~src_pixel[31:24];
			sr_s1 <= src_pixel[23:16];
			sg_s1 <= src_pixel[15:8];
			sb_s1 <= src_pixel[7:0];
			dr_s1 <= EXP5[dst_pixel[15:11]];
			dg_s1 <= EXP6[dst_pixel[10:5]];
			db_s1 <= EXP5[dst_pixel[4:0]];
			opq_s1 <= (src_pixel[31:24] == 8'hFF);
		end
	end

	// The two weights add to 255, so each sum stays within 16 bits.
	always_ff @(posedge clk) begin
		if (en.s2) begin
			mr_s2 <= 16'(sr_s1 * a_s1) + 16'(dr_s1 * na_s1);
			mg_s2 <= 16'(sg_s1 * a_s1) + 16'(dg_s1 * na_s1);
			mb_s2 <= 16'(sb_s1 * a_s1) + 16'(db_s1 * na_s1);
			src565_s2 <= pack565(sr_s1, sg_s1, sb_s1);
			opq_s2 <= opq_s1;
		end
	end

	assign mixed = pack565(div255(mr_s2), div255(mg_s2), div255(mb_s2));

	always_comb begin
		if (!we_s2) begin
			color = '0;
		end else if (opq_s2) begin
			color = src565_s2;
		end else begin
			color = mixed;
		end
	end

endmodule

// ----- sv/sprite_alpha_blend_rgb565_top.sv -----
// Top level of the ARGB8888-over-RGB565 sprite blender.
//
// Input stream (s_axis): one sprite pixel per transfer, carrying its column and
// row within the sprite, the ARGB8888 source and the RGB565 framebuffer pixel
// under it. Output stream (m_axis): one result per input, in order; tuser is the
// write enable, tdata holds the framebuffer address and the new color. When the
// write enable is low, address and color are zero.
// The sprite origin and size are set through the cfg port; the user must write them while no pixel is in
// flight, as the block does not enforce this. A write takes effect at the clock edge where cfg_we is high.
// The block is a three-stage pipeline and takes one pixel every cycle while the
// receiver holds m_axis_tready high. The last stage is the output
// register. When the receiver holds tready low, the pipeline fills its empty
// stages and then drops s_axis_tready; nothing is lost or repeated. The clamp,
// clip and address multiply set the first two stages, the division by 255 the
// last. Reset clears all valid bits and the sprite registers; the data registers
// are not reset, since the valid bits mark what they hold.
module sprite_alpha_blend_rgb565_top import sab_pkg::*; #(
	parameter int SCREEN_WIDTH = 320,
	parameter int SCREEN_HEIGHT = 240,
	parameter int MAX_SPRITE_SIDE = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [7:0] sprite_col, [15:8] sprite_line, [47:16] src_pixel, [63:48] dst_pixel
	input  logic [63:0]           s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [16:0] pixel_address, [32:17] pixel_color, [39:33] zero
	output logic [39:0]           m_axis_tdata,
	// [0] write_enable
	output logic [0:0]            m_axis_tuser
);

	logic signed [10:0] sprite_left_q;
	logic signed [10:0] sprite_top_q;
	logic [8:0]         sprite_width_q;
	logic [8:0]         sprite_height_q;

	logic v_s1, v_s2, v_s3;
	logic ready1, ready2, ready3;
	stage_en_t en;

	logic              we_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [COLOR_W-1:0] color;
	logic              we_s3;
	logic [ADDR_W-1:0] addr_s3;
	logic [COLOR_W-1:0] color_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sprite_left_q <= '0;
			sprite_top_q <= '0;
			sprite_width_q <= '0;
			sprite_height_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPRITE_LEFT:   sprite_left_q <= cfg_wdata;
				REG_SPRITE_TOP:    sprite_top_q <= cfg_wdata;
				REG_SPRITE_WIDTH:  sprite_width_q <= cfg_wdata[8:0];
				REG_SPRITE_HEIGHT: sprite_height_q <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or its contents move on in the same cycle.
	assign ready3 = !v_s3 || m_axis_tready;
	assign ready2 = !v_s2 || ready3;
	assign ready1 = !v_s1 || ready2;
	assign en.s1 = ready1;
	assign en.s2 = ready2;
	assign en.s3 = ready3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready1) v_s1 <= s_axis_tvalid;
			if (ready2) v_s2 <= v_s1;
			if (ready3) v_s3 <= v_s2;
		end
	end

	sab_geom #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.MAX_SPRITE_SIDE(MAX_SPRITE_SIDE)
	) u_geom (
		.clk(clk),
		.en(en),
		.sprite_left(sprite_left_q),
		.sprite_top(sprite_top_q),
		.sprite_width(sprite_width_q),
		.sprite_height(sprite_height_q),
		.sprite_col(s_axis_tdata[7:0]),
		.sprite_line(s_axis_tdata[15:8]),
		.alpha(s_axis_tdata[47:40]),
		.we_s2(we_s2),
		.addr_s2(addr_s2)
	);

	sab_blend u_blend (
		.clk(clk),
		.en(en),
		.src_pixel(s_axis_tdata[47:16]),
		.dst_pixel(s_axis_tdata[63:48]),
		.we_s2(we_s2),
		.color(color)
	);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			we_s3 <= we_s2;
			addr_s3 <= addr_s2;
			color_s3 <= color;
		end
	end

	assign s_axis_tready = ready1;
	assign m_axis_tvalid = v_s3;
	assign m_axis_tdata = {7'd0, color_s3, addr_s3};
	assign m_axis_tuser = we_s3;

endmodule

// ----- sv/sab_checker.sv -----
// Port-level checks for the sprite blender, bound to its top level.
module sab_checker #(
	parameter int SCREEN_WIDTH = 320,
	parameter int SCREEN_HEIGHT = 240
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	localparam longint AREA = longint'(SCREEN_WIDTH) * longint'(SCREEN_HEIGHT);
	localparam logic [17:0] AREA_L = (AREA > 131072) ? 18'h3FFFF : 18'(AREA);

	// A suppressed write carries neither address nor color.
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == 40'd0)
		else $error("suppressed write with nonzero payload");

	// An enabled write addresses a pixel inside the framebuffer.
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> {1'b0, m_axis_tdata[16:0]} < AREA_L)
		else $error("write address beyond the framebuffer");

	// A receiver that is ready never blocks the input side.
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output is ready");

	// With no stall, a transferred pixel passes through the pipeline to a valid output.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(s_axis_tvalid && s_axis_tready, 3) && $past(arst_n, 3)
		&& $past(arst_n, 2) && $past(arst_n, 1)
		&& $past(m_axis_tready, 2) && $past(m_axis_tready, 1) |-> m_axis_tvalid)
		else $error("result missing after pipeline latency");

	// A stalled result holds until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
		&& $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

endmodule

bind sprite_alpha_blend_rgb565_top sab_checker #(
	.SCREEN_WIDTH(SCREEN_WIDTH),
	.SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_sab_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata),
	.m_axis_tuser(m_axis_tuser)
);
